// ===== hdl/apsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared types and constants of the all-pairs shortest path core.
// ----------------------------------------------------------------------------
package apsp_pkg;

    // Matrix geometry
    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int DEPTH     = 1 << ADDR_W;

    // Field widths
    localparam int DIST_W    = 14;
    localparam int FNODE_W   = 6;
    localparam int NCOUNT_W  = 7;

    // Distance marking a pair with no path
    localparam logic [DIST_W-1:0] UNREACH_DIST = DIST_W'(10000);
    localparam logic [DIST_W-1:0] ZERO_DIST    = '0;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_WRITE = 2'd1,
        OP_RUN   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Request payload
    typedef struct packed {
        op_t                opcode;
        logic [FNODE_W-1:0] src_node;
        logic [FNODE_W-1:0] dst_node;
        logic [DIST_W-1:0]  edge_cost;
    } cmd_t;

    // Result payload
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              unreachable;
    } rsp_t;

    // Matrix memory access from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DIST_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_req_t;

    // Matrix memory read data
    typedef struct packed {
        logic [DIST_W-1:0] rdata_a;
        logic [DIST_W-1:0] rdata_b;
    } ram_rsp_t;

endpackage

// ===== hdl/apsp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hdl/apsp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_seq
// Request sequencer: clear sweep, symmetric edge write, distance read and the
// Floyd-Warshall relaxation walk over the matrix memory.
// ----------------------------------------------------------------------------
module apsp_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  apsp_pkg::cmd_t                  request,
    input  logic [apsp_pkg::NCOUNT_W-1:0]   node_count,
    output logic                            busy,
    output logic                            result_valid,
    output apsp_pkg::rsp_t                  result,
    output apsp_pkg::ram_req_t              ram_req,
    input  apsp_pkg::ram_rsp_t              ram_rsp
);

    import apsp_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLR   = 8'b0000_0010,
        S_WR2   = 8'b0000_0100,
        S_RDW   = 8'b0000_1000,
        S_ROW   = 8'b0001_0000,
        S_ROWW  = 8'b0010_0000,
        S_COL   = 8'b0100_0000,
        S_DRAIN = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [NODE_W-1:0]   k_reg, k_next;
    logic [NODE_W-1:0]   i_reg, i_next;
    logic [NODE_W-1:0]   j_reg, j_next;
    logic [NODE_W-1:0]   pj_reg, pj_next;
    logic                pend_reg, pend_next;
    logic [NODE_W-1:0]   nlast_reg, nlast_next;
    logic [DIST_W-1:0]   ik_reg, ik_next;
    logic [NODE_W-1:0]   src_reg, src_next;
    logic [NODE_W-1:0]   dst_reg, dst_next;
    logic [DIST_W-1:0]   cost_reg, cost_next;
    logic                ok_reg, ok_next;
    logic                done_reg, done_next;
    rsp_t                result_reg, result_next;

    logic                req_ok;
    logic [DIST_W-1:0]   cost_sat;
    logic [DIST_W:0]     sum;
    logic                row_last;
    logic                k_last;
    logic [DIST_W-1:0]   rd_dist;

    // Decode request fields
    assign req_ok   = (32'(request.src_node) < MAX_NODES) &&
                      (32'(request.dst_node) < MAX_NODES);
    assign cost_sat = (request.edge_cost > UNREACH_DIST) ? UNREACH_DIST : request.edge_cost;

    // Relaxation datapath: ik plus kj against ij
    assign sum      = {1'b0, ik_reg} + {1'b0, ram_rsp.rdata_a};
    assign row_last = (i_reg == nlast_reg);
    assign k_last   = (k_reg == nlast_reg);
    assign rd_dist  = ok_reg ? ram_rsp.rdata_a : UNREACH_DIST;

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        pj_next     = pj_reg;
        pend_next   = 1'b0;
        nlast_next  = nlast_reg;
        ik_next     = ik_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        cost_next   = cost_reg;
        ok_next     = ok_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        ram_req.we      = 1'b0;
        ram_req.waddr   = {i_reg, pj_reg};
        ram_req.wdata   = sum[DIST_W-1:0];
        ram_req.raddr_a = {i_reg, k_reg};
        ram_req.raddr_b = {i_reg, j_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    src_next  = NODE_W'(request.src_node);
                    dst_next  = NODE_W'(request.dst_node);
                    cost_next = cost_sat;
                    ok_next   = req_ok;
                    unique case (request.opcode)
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        OP_WRITE:
                        begin
                            // First half of the symmetric write
                            ram_req.we    = req_ok;
                            ram_req.waddr = {NODE_W'(request.src_node),
                                             NODE_W'(request.dst_node)};
                            ram_req.wdata = cost_sat;
                            state_next    = S_WR2;
                        end
                        OP_RUN:
                        begin
                            if (node_count == '0)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                            else
                            begin
                                if (32'(node_count) > MAX_NODES)
                                begin
                                    nlast_next = NODE_W'(MAX_NODES - 1);
                                end
                                else
                                begin
                                    nlast_next = NODE_W'(node_count - NCOUNT_W'(1));
                                end
                                k_next     = '0;
                                i_next     = '0;
                                state_next = S_ROW;
                            end
                        end
                        OP_READ:
                        begin
                            ram_req.raddr_a = {NODE_W'(request.src_node),
                                               NODE_W'(request.dst_node)};
                            state_next      = S_RDW;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                // Sweep one entry a cycle, zero on the diagonal
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = (clr_reg[ADDR_W-1:NODE_W] == clr_reg[NODE_W-1:0]) ?
                                ZERO_DIST : UNREACH_DIST;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1))
                begin
                    done_next   = 1'b1;
                    result_next = '0;
                    state_next  = S_IDLE;
                end
            end

            S_WR2:
            begin
                // Mirror entry
                ram_req.we    = ok_reg;
                ram_req.waddr = {dst_reg, src_reg};
                ram_req.wdata = cost_reg;
                done_next     = 1'b1;
                result_next   = '0;
                state_next    = S_IDLE;
            end

            S_RDW:
            begin
                done_next               = 1'b1;
                result_next.distance    = rd_dist;
                result_next.unreachable = (rd_dist == UNREACH_DIST);
                state_next              = S_IDLE;
            end

            S_ROW:
            begin
                // Fetch d[i][k] for this row
                ram_req.raddr_a = {i_reg, k_reg};
                state_next      = S_ROWW;
            end

            S_ROWW, S_DRAIN:
            begin
                if ((state_reg == S_ROWW) && (ram_rsp.rdata_a < UNREACH_DIST))
                begin
                    ik_next    = ram_rsp.rdata_a;
                    j_next     = '0;
                    state_next = S_COL;
                end
                else
                begin
                    // Retire the last column of the row
                    if (state_reg == S_DRAIN)
                    begin
                        ram_req.we = pend_reg && (ram_rsp.rdata_a < UNREACH_DIST) &&
                                     (sum < {1'b0, ram_rsp.rdata_b});
                    end
                    // Advance to the next row or intermediate node
                    if (row_last && k_last)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                        state_next  = S_IDLE;
                    end
                    else if (row_last)
                    begin
                        i_next     = '0;
                        k_next     = k_reg + NODE_W'(1);
                        state_next = S_ROW;
                    end
                    else
                    begin
                        i_next     = i_reg + NODE_W'(1);
                        state_next = S_ROW;
                    end
                end
            end

            S_COL:
            begin
                // Issue d[k][j] and d[i][j]; write back the previous column
                ram_req.raddr_a = {k_reg, j_reg};
                ram_req.raddr_b = {i_reg, j_reg};
                ram_req.we      = pend_reg && (ram_rsp.rdata_a < UNREACH_DIST) &&
                                  (sum < {1'b0, ram_rsp.rdata_b});
                pend_next       = 1'b1;
                pj_next         = j_reg;
                j_next          = j_reg + NODE_W'(1);
                if (j_reg == nlast_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
        end
    end

    // Payload and loop registers
    always_ff @(posedge clk)
    begin
        clr_reg    <= clr_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        pj_reg     <= pj_next;
        nlast_reg  <= nlast_next;
        ik_reg     <= ik_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        cost_reg   <= cost_next;
        ok_reg     <= ok_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = done_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/all_pairs_shortest_path_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_core
// Distance matrix of an undirected graph with clear, edge write,
// Floyd-Warshall relaxation and distance read.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low, and every
// request gives exactly one result, shown for one cycle with result_valid high
// in the cycle after the request finishes; the receiver cannot stall it, so
// capture it when the strobe is seen. Busy is already low in the strobe cycle.
// Request timing is set by the single-write, dual-read matrix memory. An edge
// write stores one mirrored entry in the accept cycle and the other in the next
// state; a read registers the addressed entry; a clear sweeps the matrix after
// the accept, one entry a cycle; a run, for each row, fetches d[i][k] (row and
// row wait states), then takes one column a cycle and a retire step; rows whose
// d[i][k] is unreachable skip the columns. A run with node_count zero finishes
// at once. Read the matrix only after a clear.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  apsp_pkg::cmd_t                request,
    output logic                          result_valid,
    output apsp_pkg::rsp_t                result,
    input  logic                          cfg_wr_en,
    input  logic [apsp_pkg::NCOUNT_W-1:0] cfg_wr_data
);

    import apsp_pkg::*;

    logic [NCOUNT_W-1:0] node_count_reg;
    ram_req_t            ram_req;
    ram_rsp_t            ram_rsp;

    // Hold the node count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NCOUNT_W'(64);
        end
        else if (cfg_wr_en)
        begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // Sequencer
    apsp_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request      (request),
        .node_count   (node_count_reg),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .ram_req      (ram_req),
        .ram_rsp      (ram_rsp)
    );

    // Distance matrix memory
    apsp_ram #(
        .WIDTH (DIST_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .rdata_a (ram_rsp.rdata_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_b (ram_rsp.rdata_b)
    );

    // A result only appears once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
    else $error("result strobe while busy");

    // An accepted request either keeps the core busy or finishes at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || result_valid))
    else $error("accepted request lost");

    // The unreachable flag agrees with the distance
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.unreachable == (result.distance == UNREACH_DIST)))
    else $error("unreachable flag mismatch");

    // No stored distance ever exceeds the unreachable value
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (ram_req.wdata <= UNREACH_DIST))
    else $error("matrix write above unreachable");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for all_pairs_shortest_path_core. A directed table
// checks the clear pattern, saturated and self edges, the mirrored write and
// a relaxation that must skip an unreachable leg. Random phases then try
// several node counts, including zero and values above the matrix size. Each
// phase holds graph sequences (clear, edge writes, relaxation, reads) mixed
// with random requests. Every result is checked against a value typed in the
// table or against a distance-matrix model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import apsp_pkg::*;

    localparam int NUM_PHASES = 12;
    localparam int NUM_ROWS   = 24;

    // Directed stimulus row; has_exp marks a result typed in by hand
    typedef struct packed {
        op_t               op;
        logic [5:0]        src;
        logic [5:0]        dst;
        logic [DIST_W-1:0] cost;
        bit                has_exp;
        logic [DIST_W-1:0] exp_dist;
        logic              unr;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
        '{OP_CLEAR, 6'd0,  6'd0,  14'd0,     1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd0,  6'd0,  14'd0,     1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd63, 6'd63, 14'd16383, 1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd0,  6'd63, 14'd0,     1'b1, UNREACH_DIST, 1'b1},
        '{OP_WRITE, 6'd0,  6'd63, 14'd0,     1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd63, 6'd0,  14'd0,     1'b1, ZERO_DIST,    1'b0},
        '{OP_WRITE, 6'd1,  6'd2,  14'd9999,  1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd2,  6'd1,  14'd0,     1'b1, 14'd9999,     1'b0},
        '{OP_WRITE, 6'd3,  6'd4,  14'd16383, 1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd4,  6'd3,  14'd0,     1'b1, UNREACH_DIST, 1'b1},
        '{OP_WRITE, 6'd5,  6'd6,  14'd10000, 1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd5,  6'd6,  14'd0,     1'b1, UNREACH_DIST, 1'b1},
        '{OP_WRITE, 6'd7,  6'd7,  14'd5,     1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd7,  6'd7,  14'd0,     1'b1, 14'd5,        1'b0},
        '{OP_WRITE, 6'd42, 6'd21, 14'd5461,  1'b0, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd21, 6'd42, 14'd0,     1'b0, ZERO_DIST,    1'b0},
        '{OP_WRITE, 6'd8,  6'd9,  14'd3,     1'b1, ZERO_DIST,    1'b0},
        '{OP_WRITE, 6'd9,  6'd10, 14'd4,     1'b1, ZERO_DIST,    1'b0},
        '{OP_WRITE, 6'd10, 6'd11, 14'd10000, 1'b1, ZERO_DIST,    1'b0},
        '{OP_RUN,   6'd0,  6'd0,  14'd0,     1'b1, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd8,  6'd10, 14'd0,     1'b1, 14'd7,        1'b0},
        '{OP_READ,  6'd8,  6'd11, 14'd0,     1'b1, UNREACH_DIST, 1'b1},
        '{OP_READ,  6'd7,  6'd7,  14'd0,     1'b0, ZERO_DIST,    1'b0},
        '{OP_READ,  6'd63, 6'd2,  14'd0,     1'b0, ZERO_DIST,    1'b0}
    };

    // Node count, request budget and sender idle percentage of each phase
    localparam logic [NCOUNT_W-1:0] PHASE_NODES [0:NUM_PHASES-1] =
        '{7'd5, 7'd0, 7'd1, 7'd127, 7'd8, 7'd2, 7'd12, 7'd64, 7'd6, 7'd3, 7'd65, 7'd10};
    localparam int PHASE_ITEMS [0:NUM_PHASES-1] =
        '{160, 60, 80, 60, 200, 120, 200, 60, 200, 160, 60, 200};
    localparam int PHASE_IDLE [0:NUM_PHASES-1] =
        '{30, 50, 20, 40, 25, 60, 15, 30, 35, 20, 0, 0};

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    cmd_t                request;
    logic                result_valid;
    rsp_t                result;
    logic                cfg_wr_en;
    logic [NCOUNT_W-1:0] cfg_wr_data;

    // Bench copy of the matrix and the node count register
    logic [DIST_W-1:0]   dist_mat [0:MAX_NODES-1][0:MAX_NODES-1];
    logic [NCOUNT_W-1:0] node_count_cfg;

    rsp_t        pending_dist [$];
    rsp_t        want_rsp;
    int unsigned fail_count;
    int unsigned sent_count;
    int unsigned idle_pct;

    all_pairs_shortest_path_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the matrix copy and return its result
    function automatic rsp_t apply_request(input cmd_t c);
        rsp_t        r;
        int unsigned n;
        int unsigned ik;
        int unsigned kj;
        logic [DIST_W-1:0] cost;
        r = '0;
        case (c.opcode)
            OP_CLEAR:
                for (int i = 0; i < MAX_NODES; i++)
                    for (int j = 0; j < MAX_NODES; j++)
                        dist_mat[i][j] = (i == j) ? ZERO_DIST : UNREACH_DIST;
            OP_WRITE:
            begin
                cost = (c.edge_cost > UNREACH_DIST) ? UNREACH_DIST : c.edge_cost;
                dist_mat[c.src_node][c.dst_node] = cost;
                dist_mat[c.dst_node][c.src_node] = cost;
            end
            OP_RUN:
            begin
                n = (node_count_cfg > MAX_NODES) ? MAX_NODES : node_count_cfg;
                for (int k = 0; k < n; k++)
                    for (int i = 0; i < n; i++)
                    begin
                        ik = dist_mat[i][k];
                        if (ik < UNREACH_DIST)
                            for (int j = 0; j < n; j++)
                            begin
                                kj = dist_mat[k][j];
                                if (kj < UNREACH_DIST && ik + kj < dist_mat[i][j])
                                    dist_mat[i][j] = DIST_W'(ik + kj);
                            end
                    end
            end
            default:
            begin
                r.distance    = dist_mat[c.src_node][c.dst_node];
                r.unreachable = (r.distance == UNREACH_DIST);
            end
        endcase
        return r;
    endfunction

    // Mostly a node inside the active set, now and then any node
    function automatic logic [5:0] pick_node(input int unsigned n);
        if (n >= 2 && $urandom_range(0, 9) != 0)
            return 6'($urandom_range(0, n - 1));
        return 6'($urandom_range(0, MAX_NODES - 1));
    endfunction

    // Present a request, hold it until taken, then queue its result
    task automatic issue_request(input cmd_t c, input bit has_exp, input rsp_t exp_rsp);
        rsp_t model_rsp;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= c;
        do
            @(posedge clk);
        while (busy);
        model_rsp = apply_request(c);
        pending_dist.insert(pending_dist.size(), has_exp ? exp_rsp : model_rsp);
        sent_count++;
    endtask

    // Check every result against the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_dist.size() == 0)
            begin
                $error("unrequested result: distance=%0d unreachable=%0b",
                       result.distance, result.unreachable);
                fail_count++;
            end
            else
            begin
                want_rsp = pending_dist.pop_front();
                if (result.distance !== want_rsp.distance)
                begin
                    $error("distance: expected %0d, got %0d", want_rsp.distance, result.distance);
                    fail_count++;
                end
                if (result.unreachable !== want_rsp.unreachable)
                begin
                    $error("unreachable: expected %0b, got %0b",
                           want_rsp.unreachable, result.unreachable);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cmd_t        c;
        rsp_t        typed_rsp;
        int unsigned n_eff;
        int unsigned budget;
        int unsigned reps;
        int unsigned wait_cycles;

        rst_n          = 1'b0;
        start          = 1'b0;
        request        = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        node_count_cfg = NCOUNT_W'(MAX_NODES);
        fail_count     = 0;
        sent_count     = 0;
        idle_pct       = 25;
        for (int i = 0; i < MAX_NODES; i++)
            for (int j = 0; j < MAX_NODES; j++)
                dist_mat[i][j] = ZERO_DIST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table at the reset node count
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            c                     = '0;
            c.opcode              = DIRECTED_ROWS[r].op;
            c.src_node            = DIRECTED_ROWS[r].src;
            c.dst_node            = DIRECTED_ROWS[r].dst;
            c.edge_cost           = DIRECTED_ROWS[r].cost;
            typed_rsp.distance    = DIRECTED_ROWS[r].exp_dist;
            typed_rsp.unreachable = DIRECTED_ROWS[r].unr;
            issue_request(c, DIRECTED_ROWS[r].has_exp, typed_rsp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // Drain, then reprogram the node count while idle
            start <= 1'b0;
            while (pending_dist.size() != 0) @(posedge clk);
            repeat (2) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= PHASE_NODES[p];
            @(posedge clk);
            cfg_wr_en      <= 1'b0;
            node_count_cfg  = PHASE_NODES[p];
            n_eff    = (PHASE_NODES[p] > MAX_NODES) ? MAX_NODES : PHASE_NODES[p];
            idle_pct = PHASE_IDLE[p];
            budget   = sent_count + PHASE_ITEMS[p];

            while (sent_count < budget)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    // Noise: fully random requests
                    repeat ($urandom_range(1, 4))
                    begin
                        c           = '0;
                        c.opcode    = op_t'($urandom_range(0, 3));
                        c.src_node  = 6'($urandom_range(0, MAX_NODES - 1));
                        c.dst_node  = 6'($urandom_range(0, MAX_NODES - 1));
                        c.edge_cost = DIST_W'($urandom_range(0, 16383));
                        issue_request(c, 1'b0, '0);
                    end
                end
                else
                begin
                    // Graph sequence: optional clear, edges, relax, reads
                    if ($urandom_range(0, 3) == 0 || (n_eff > 16 && $urandom_range(0, 1) == 0))
                    begin
                        c        = '0;
                        c.opcode = OP_CLEAR;
                        issue_request(c, 1'b0, '0);
                    end
                    reps = (n_eff > 16) ? $urandom_range(1, 6)
                                        : $urandom_range(1, (n_eff < 2) ? 4 : 2 * n_eff);
                    repeat (reps)
                    begin
                        c          = '0;
                        c.opcode   = OP_WRITE;
                        c.src_node = pick_node(n_eff);
                        c.dst_node = pick_node(n_eff);
                        case ($urandom_range(0, 9))
                            0:       c.edge_cost = DIST_W'($urandom_range(9995, 16383));
                            1:       c.edge_cost = DIST_W'($urandom_range(0, 9999));
                            default: c.edge_cost = DIST_W'($urandom_range(0, 60));
                        endcase
                        issue_request(c, 1'b0, '0);
                    end
                    c           = '0;
                    c.opcode    = OP_RUN;
                    c.edge_cost = DIST_W'($urandom_range(0, 16383));
                    issue_request(c, 1'b0, '0);
                    reps = (n_eff > 16) ? $urandom_range(10, 30) : $urandom_range(2, 8);
                    repeat (reps)
                    begin
                        c          = '0;
                        c.opcode   = OP_READ;
                        c.src_node = pick_node(n_eff);
                        c.dst_node = pick_node(n_eff);
                        issue_request(c, 1'b0, '0);
                    end
                end
            end
        end

        // Drain the last results, then allow a few trailing cycles
        start <= 1'b0;
        wait_cycles = 0;
        while (pending_dist.size() != 0 && wait_cycles < 2_000_000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (16) @(posedge clk);
        if (pending_dist.size() != 0)
        begin
            $error("%0d results never arrived", pending_dist.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== all_pairs_shortest_path_core.f =====
hdl/apsp_pkg.sv
hdl/apsp_ram.sv
hdl/apsp_seq.sv
hdl/all_pairs_shortest_path_core.sv
tb/tb_top.sv
